/* sv/slfr_pkg.sv */
package slfr_pkg;

  localparam logic [7:0] SYNC_FLAG = 8'h7E;
  localparam int STORE_DEPTH = 64;
  localparam int MAX_PAYLOAD_DEFAULT = 64;
  localparam int CAPACITY_DEFAULT =
    (MAX_PAYLOAD_DEFAULT < STORE_DEPTH) ? MAX_PAYLOAD_DEFAULT : STORE_DEPTH;
  localparam int ADDR_W_DEFAULT = (CAPACITY_DEFAULT > 1) ? $clog2(CAPACITY_DEFAULT) : 1;
  localparam int POS_W = 6;
  localparam int RUN_W = 7;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHK1,
    PH_CHK2
  } phase_t;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_LOAD,
    RP_SHOW
  } replay_state_t;

  typedef struct packed {
    logic [7:0]       command;
    logic [7:0]       length;
    logic [RUN_W-1:0] run_count;
    logic             truncated;
  } frame_info_t;

endpackage

/* sv/sync_len_frame_receiver_unit.sv */
// The first word of a frame is valid once the replay has passed its load state after the
// edge that takes the second check byte. Throughput: one rx byte per cycle while no frame
// replays; replay alternates a load state behind the registered payload RAM read and a
// show state for each word, so rx_ready stays low until the last word is taken, output
// stalls included, and an empty frame still replays one word. Reset (rst, synchronous,
// active high) returns to sync hunt and idles the replay; the payload RAM is not cleared.
module sync_len_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  output logic                        rx_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  command,
  output logic [7:0]                  frame_length,
  output logic                        has_payload,
  output logic [7:0]                  payload_byte,
  output logic [slfr_pkg::POS_W-1:0]  byte_position,
  output logic                        truncated,
  output logic                        last
);

  import slfr_pkg::*;

  // Stored capacity is the payload limit clipped to the store depth.
  localparam int CAPACITY = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              byte_take;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              frame_done;
  logic              busy;
  frame_info_t       info;

  // Hold off rx words while a frame replays; frame header registers stay put meanwhile.
  assign rx_ready  = !busy;
  assign byte_take = rx_valid && rx_ready;

  // Receive side: sync hunt, header capture, payload writes into the store.
  slfr_rx #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W)
  ) u_rx (
    .clk        (clk),
    .rst        (rst),
    .byte_take  (byte_take),
    .rx_byte    (rx_byte),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .frame_done (frame_done),
    .info       (info)
  );

  // Payload store: one write port from receive, one registered read port for replay.
  slfr_ram #(
    .WIDTH  (8),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Replay: read address sits at the next index so data is ready when a word is taken.
  slfr_replay #(
    .ADDR_W (ADDR_W)
  ) u_replay (
    .clk           (clk),
    .rst           (rst),
    .frame_done    (frame_done),
    .info          (info),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .frame_length  (frame_length),
    .has_payload   (has_payload),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .truncated     (truncated),
    .last          (last)
  );

endmodule

/* sv/slfr_ram.sv */
module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/slfr_rx.sv */
module slfr_rx #(
  parameter int CAPACITY = slfr_pkg::CAPACITY_DEFAULT,
  parameter int ADDR_W = slfr_pkg::ADDR_W_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_take,
  input  logic [7:0]                rx_byte,
  output logic                      wr_en,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [7:0]                wr_data,
  output logic                      frame_done,
  output slfr_pkg::frame_info_t     info
);

  import slfr_pkg::*;

  localparam logic [7:0] CAP8 = 8'(CAPACITY);

  phase_t     phase, phase_next;
  logic [7:0] payload_count;
  logic [7:0] declared_length;
  logic [7:0] held_command;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC1: if (rx_byte == SYNC_FLAG) phase_next = PH_SYNC2;
      PH_SYNC2: phase_next = (rx_byte == SYNC_FLAG) ? PH_CMD : PH_SYNC1;
      PH_CMD:   phase_next = PH_LEN;
      PH_LEN:   phase_next = (rx_byte == 8'd0) ? PH_CHK1 : PH_DATA;
      PH_DATA:  if (payload_count + 8'd1 >= declared_length) phase_next = PH_CHK1;
      PH_CHK1:  phase_next = PH_CHK2;
      PH_CHK2:  phase_next = PH_SYNC1;
      default:  phase_next = PH_SYNC1;
    endcase
  end

  // store port and frame summary
  always_comb begin
    wr_en      = byte_take && (phase == PH_DATA) && (payload_count < CAP8);
    wr_addr    = payload_count[ADDR_W-1:0];
    wr_data    = rx_byte;
    frame_done = byte_take && (phase == PH_CHK2);
    info.command   = held_command;
    info.length    = declared_length;
    info.truncated = declared_length > CAP8;
    info.run_count = info.truncated ? RUN_W'(CAPACITY) : declared_length[RUN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      payload_count   <= '0;
      declared_length <= '0;
      held_command    <= '0;
    end else if (byte_take) begin
      phase <= phase_next;
      if (phase == PH_CMD) held_command <= rx_byte;
      if (phase == PH_LEN) begin
        declared_length <= rx_byte;
        payload_count   <= '0;
      end
      if (phase == PH_DATA) payload_count <= payload_count + 8'd1;
    end
  end

endmodule

/* sv/slfr_replay.sv */
module slfr_replay #(
  parameter int ADDR_W = slfr_pkg::ADDR_W_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_done,
  input  slfr_pkg::frame_info_t       info,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  command,
  output logic [7:0]                  frame_length,
  output logic                        has_payload,
  output logic [7:0]                  payload_byte,
  output logic [slfr_pkg::POS_W-1:0]  byte_position,
  output logic                        truncated,
  output logic                        last
);

  import slfr_pkg::*;

  replay_state_t    state, state_next;
  logic [RUN_W-1:0] idx;
  logic             load;
  logic             word_taken;

  always_comb begin
    state_next = state;
    unique case (state)
      RP_IDLE: if (frame_done) state_next = RP_LOAD;
      RP_LOAD: state_next = RP_SHOW;
      RP_SHOW: if (out_ready) state_next = last ? RP_IDLE : RP_LOAD;
      default: state_next = RP_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != RP_IDLE);
    load       = (state == RP_LOAD);
    out_valid  = (state == RP_SHOW);
    word_taken = out_valid && out_ready;
    rd_addr    = idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RP_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        idx <= idx + RUN_W'(1);
      end else if (word_taken && last) begin
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command       <= info.command;
      frame_length  <= info.length;
      truncated     <= info.truncated;
      has_payload   <= (info.run_count != '0);
      payload_byte  <= (info.run_count != '0) ? rd_data : 8'd0;
      byte_position <= idx[POS_W-1:0];
      last          <= (info.run_count == '0) || (idx + RUN_W'(1) == info.run_count);
    end
  end

endmodule

/* tb/tb_sync_len_frame_receiver_unit.sv */
module tb_sync_len_frame_receiver_unit;
  import slfr_pkg::*;

  // Frames longer than this lose their tail and replay with the truncated flag.
  localparam int CAPACITY = CAPACITY_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PLAN_BYTES = 180;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_ROWS = 26;

  // One output word, fields in port order.
  typedef struct packed {
    logic [7:0]       command;
    logic [7:0]       frame_length;
    logic             has_payload;
    logic [7:0]       payload_byte;
    logic [POS_W-1:0] byte_position;
    logic             truncated;
    logic             last;
  } frame_word_t;

  // One link byte to send. A typed row carries the word it must produce;
  // a row marked drain_first is held back until every expected word has come.
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    bit          drain_first;
    frame_word_t want;
  } stim_row_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_MOSTLY
  } ready_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 rx_valid = 1'b0;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_ready = 1'b0;
  logic                 rx_ready;
  logic                 out_valid;
  logic [7:0]           command;
  logic [7:0]           frame_length;
  logic                 has_payload;
  logic [7:0]           payload_byte;
  logic [POS_W-1:0]     byte_position;
  logic                 truncated;
  logic                 last;

  sync_len_frame_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_ready      (rx_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .frame_length  (frame_length),
    .has_payload   (has_payload),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .truncated     (truncated),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed bytes: broken sync, a zero-length frame with extreme command and
  // check bytes, a one-byte frame with extreme payload, then a short frame that
  // follows a broken sync and a fresh sync pair.
  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '{8'hFF, 8'h00, 1'b0, 8'h00, 6'd0, 1'b0, 1'b1}},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b1, 1'b0, '{8'h00, 8'h01, 1'b1, 8'hFF, 6'd0, 1'b0, 1'b1}},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b0, 1'b0, '0}
  };

  stim_row_t   link_plan[$];
  frame_word_t expected_words[$];

  // Deframer state as the testbench sees it.
  phase_t      pr_phase = PH_SYNC1;
  logic [7:0]  pr_count = 8'h00;
  logic [7:0]  pr_length = 8'h00;
  logic [7:0]  pr_command = 8'h00;
  logic [7:0]  pr_store [STORE_DEPTH];

  int unsigned cycles = 0;
  int          bytes_taken = 0;
  int          words_checked = 0;
  int          fail_count = 0;
  int          frames_seen = 0;
  int          truncated_frames = 0;
  int          empty_frames = 0;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  function automatic string word_text(input frame_word_t w);
    return $sformatf("cmd=%02h len=%02h has=%0b data=%02h pos=%0d trunc=%0b last=%0b",
                     w.command, w.frame_length, w.has_payload, w.payload_byte,
                     w.byte_position, w.truncated, w.last);
  endfunction

  // Advance the deframer by one link byte; on the second check byte queue the
  // replay of the frame, unless the row supplies its own expected word.
  task automatic deframe_byte(input logic [7:0] b, input bit keep);
    frame_word_t w;
    int          n;
    int          k;
    bit          cut;
    case (pr_phase)
      PH_SYNC1: if (b == SYNC_FLAG) pr_phase = PH_SYNC2;
      PH_SYNC2: pr_phase = (b == SYNC_FLAG) ? PH_CMD : PH_SYNC1;
      PH_CMD: begin
        pr_command = b;
        pr_phase = PH_LEN;
      end
      PH_LEN: begin
        pr_length = b;
        pr_count = 8'h00;
        pr_phase = (b == 8'h00) ? PH_CHK1 : PH_DATA;
      end
      PH_DATA: begin
        // Count every byte, store only what fits.
        if (pr_count < CAPACITY) pr_store[pr_count[POS_W-1:0]] = b;
        pr_count = pr_count + 8'd1;
        if (pr_count >= pr_length) pr_phase = PH_CHK1;
      end
      PH_CHK1: pr_phase = PH_CHK2;
      PH_CHK2: begin
        pr_phase = PH_SYNC1;
        cut = (pr_length > CAPACITY);
        n = cut ? CAPACITY : int'(pr_length);
        frames_seen++;
        if (cut) truncated_frames++;
        if (n == 0) begin
          empty_frames++;
          w = '{pr_command, pr_length, 1'b0, 8'h00, 6'd0, 1'b0, 1'b1};
          if (keep) expected_words.push_back(w);
        end
        for (k = 0; k < n; k++) begin
          w = '{pr_command, pr_length, 1'b1, pr_store[k], 6'(k), cut, (k == n - 1)};
          if (keep) expected_words.push_back(w);
        end
      end
      default: pr_phase = PH_SYNC1;
    endcase
  endtask

  function automatic stim_row_t plain_row(input logic [7:0] b);
    stim_row_t r;
    r = '{b, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == SYNC_FLAG) ? ~b : b;
  endfunction

  // Mostly short frames, some empty, a few of medium length.
  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 0;
    if (pick < 80) return $urandom_range(1, 8);
    return $urandom_range(9, 24);
  endfunction

  // Queue one well-formed frame with random command, payload and check bytes.
  task automatic add_frame(input int len, input bit drain_first);
    stim_row_t r;
    int        k;
    r = plain_row(SYNC_FLAG);
    r.drain_first = drain_first;
    link_plan.push_back(r);
    link_plan.push_back(plain_row(SYNC_FLAG));
    link_plan.push_back(plain_row(8'($urandom)));
    link_plan.push_back(plain_row(8'(len)));
    for (k = 0; k < len; k++) link_plan.push_back(plain_row(8'($urandom)));
    repeat (2) link_plan.push_back(plain_row(8'($urandom)));
  endtask

  // Sample both handshakes at the rising edge. Predict on every accepted byte,
  // check every accepted word against the oldest expectation.
  always @(posedge clk) begin : monitor
    frame_word_t got;
    frame_word_t want;
    string       bad;
    cycles++;
    if (!rst) begin
      if (rx_valid && rx_ready) begin
        deframe_byte(rx_byte, !link_plan[bytes_taken].typed);
        if (link_plan[bytes_taken].typed) expected_words.push_back(link_plan[bytes_taken].want);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got = {command, frame_length, has_payload, payload_byte, byte_position, truncated, last};
        if (expected_words.size() == 0) begin
          note_failure($sformatf("word %0d arrived with none expected: %s",
                                 words_checked, word_text(got)));
        end else begin
          want = expected_words.pop_front();
          bad = "";
          if (got.command !== want.command) bad = {bad, " command"};
          if (got.frame_length !== want.frame_length) bad = {bad, " frame_length"};
          if (got.has_payload !== want.has_payload) bad = {bad, " has_payload"};
          if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
          if (got.byte_position !== want.byte_position) bad = {bad, " byte_position"};
          if (got.truncated !== want.truncated) bad = {bad, " truncated"};
          if (got.last !== want.last) bad = {bad, " last"};
          if (bad != "") begin
            note_failure($sformatf("word %0d differs in%s: expected %s, got %s",
                                   words_checked, bad, word_text(want), word_text(got)));
          end
        end
        words_checked++;
      end
    end
  end

  // Receiver: switch between always ready, coin flips, a repeating 16-bit pattern and
  // rare stalls. Once, in the middle of a replay, hold off for a long stretch
  // so the block backs up and drops rx_ready while bytes keep being offered.
  initial begin : receiver
    ready_mode_t mode;
    int          mode_left;
    int          step;
    logic [15:0] pattern;
    bit          held_off;
    mode = RDY_ALWAYS;
    mode_left = 0;
    step = 0;
    pattern = '1;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && words_checked >= 20 && out_valid) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
        pattern = 16'($urandom);
      end
      mode_left--;
      step++;
      case (mode)
        RDY_ALWAYS:  out_ready <= 1'b1;
        RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RDY_PATTERN: out_ready <= pattern[step % 16];
        default:     out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles: %0d of %0d bytes taken, %0d words outstanding",
             cycles, bytes_taken, link_plan.size(), expected_words.size());
    $display("** sync_len_frame_receiver_unit: FAILED **");
    $finish;
  end

  // Build the whole byte plan, release reset, then send it in bursts.
  initial begin : stimulus
    int i;
    int frame_idx;
    int pick;
    int burst_left;
    int gap;

    for (i = 0; i < DIRECTED_ROWS; i++) link_plan.push_back(directed_table[i]);

    // Fixed slots: a pause before the random part, one byte over capacity
    // (truncated, longest run), and a pause once that long frame has drained.
    // Everything else is random traffic until the plan is full.
    frame_idx = 0;
    while (link_plan.size() < PLAN_BYTES || frame_idx < 4) begin
      if (frame_idx == 0) add_frame(random_length(), 1'b1);
      else if (frame_idx == 1) add_frame(CAPACITY + 1, 1'b0);
      else if (frame_idx == 3) add_frame(random_length(), 1'b1);
      else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Line noise while hunting; keep it off the sync value so frames stay aligned.
          repeat ($urandom_range(1, 4)) link_plan.push_back(plain_row(noise_byte()));
        end else if (pick < 14) begin
          // Broken sync pair: restarts the hunt.
          link_plan.push_back(plain_row(SYNC_FLAG));
          link_plan.push_back(plain_row(noise_byte()));
        end else begin
          add_frame(random_length(), 1'b0);
        end
      end
      frame_idx++;
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    burst_left = 0;
    for (i = 0; i < link_plan.size(); i++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      if (link_plan[i].drain_first || gap != 0) rx_valid <= 1'b0;
      if (link_plan[i].drain_first) begin
        do @(negedge clk); while (expected_words.size() != 0);
      end
      repeat (gap) @(negedge clk);
      // Hold the byte until it is taken.
      rx_valid <= 1'b1;
      rx_byte <= link_plan[i].rx;
      do @(posedge clk); while (!rx_ready);
      @(negedge clk);
    end
    rx_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d link bytes forming %0d frames (%0d empty, %0d truncated)",
             bytes_taken, frames_seen, empty_frames, truncated_frames);
    $display("%0d words checked, %0d failures, %0d cycles", words_checked, fail_count, cycles);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("** sync_len_frame_receiver_unit: PASSED **");
    end else begin
      $display("** sync_len_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

endmodule
